### hdl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Shared widths, constants, codes and round functions of the TEA block
// cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int ROUNDS    = 32;
    localparam int STAGES    = 2 * ROUNDS;
    localparam int WORD_W    = 32;
    localparam int KEY_IDX_W = 2;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [KEY_IDX_W-1:0] t_key_idx;

    localparam t_word DELTA = 32'h9E3779B9;

    localparam t_key_idx KEY_ZERO  = 2'd0;
    localparam t_key_idx KEY_ONE   = 2'd1;
    localparam t_key_idx KEY_TWO   = 2'd2;
    localparam t_key_idx KEY_THREE = 2'd3;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // One TEA half-round mixing term.
    function automatic t_word mix(t_word w, t_word s, t_word ka, t_word kb);
        return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
    endfunction

    // Running sum after n additions of delta, modulo 2^32.
    function automatic t_word round_sum(int n);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

### hdl/tea_if.sv
// ----------------------------------------------------------------------------
// TEA channel interfaces
// Valid/ready channels for input blocks, result blocks and key writes.
// ----------------------------------------------------------------------------
interface tea_in_if;
    logic          valid;
    logic          ready;
    logic          action;
    tea_pkg::t_word block_left;
    tea_pkg::t_word block_right;

    modport source (output valid, action, block_left, block_right, input ready);
    modport sink   (input valid, action, block_left, block_right, output ready);
endinterface

interface tea_out_if;
    logic          valid;
    logic          ready;
    tea_pkg::t_word result_left;
    tea_pkg::t_word result_right;

    modport source (output valid, result_left, result_right, input ready);
    modport sink   (input valid, result_left, result_right, output ready);
endinterface

interface tea_cfg_if;
    logic             valid;
    logic             ready;
    tea_pkg::t_key_idx index;
    tea_pkg::t_word    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// TEA block cipher unit
// Fully unrolled TEA encrypt/decrypt pipeline, one half-round per stage.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in with an action bit (0 encrypt, 1 decrypt) and
// the two block words. Results leave on o_out as the two processed words,
// one result item per input item, in order.
// The 128-bit key is written as four 32-bit words through i_cfg, index 0
// to 3; the key port is always ready. Write keys only while the pipeline
// is empty.
// Each of the 64 register stages performs one half-round: the first stage
// loads at the accepting edge, and the last stage is the output register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and i_in.ready falls; no item is lost or repeated. Items keep
// being accepted while the output stage is empty or being taken.
// Synchronous reset empties the pipeline and clears the key to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tea_in_if.sink    i_in,
    tea_out_if.source o_out,
    tea_cfg_if.sink   i_cfg
);

    localparam int LAST = tea_pkg::STAGES - 1;

    tea_pkg::t_word r_key0;
    tea_pkg::t_word r_key1;
    tea_pkg::t_word r_key2;
    tea_pkg::t_word r_key3;

    logic           r_valid [tea_pkg::STAGES];
    logic           r_act   [tea_pkg::STAGES];
    tea_pkg::t_word r_left  [tea_pkg::STAGES];
    tea_pkg::t_word r_right [tea_pkg::STAGES];

    logic           w_valid [tea_pkg::STAGES];
    logic           w_act   [tea_pkg::STAGES];
    tea_pkg::t_word w_left  [tea_pkg::STAGES];
    tea_pkg::t_word w_right [tea_pkg::STAGES];

    logic w_adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tea_pkg::KEY_ZERO:  r_key0 <= i_cfg.data;
                tea_pkg::KEY_ONE:   r_key1 <= i_cfg.data;
                tea_pkg::KEY_TWO:   r_key2 <= i_cfg.data;
                tea_pkg::KEY_THREE: r_key3 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_valid[LAST] || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_valid[0] = i_in.valid;
    assign w_act[0]   = i_in.action;
    assign w_left[0]  = i_in.block_left;
    assign w_right[0] = i_in.block_right;

    genvar k;
    generate
        for (k = 0; k < tea_pkg::STAGES; k++) begin : g_stage
            localparam tea_pkg::t_word SUM_ENC = tea_pkg::round_sum(k / 2 + 1);
            localparam tea_pkg::t_word SUM_DEC =
                tea_pkg::round_sum(tea_pkg::ROUNDS - k / 2);

            tea_pkg::t_word n_left;
            tea_pkg::t_word n_right;

            if (k > 0) begin : g_link
                assign w_valid[k] = r_valid[k-1];
                assign w_act[k]   = r_act[k-1];
                assign w_left[k]  = r_left[k-1];
                assign w_right[k] = r_right[k-1];
            end

            if ((k % 2) == 0) begin : g_even
                always_comb begin
                    n_left  = w_left[k];
                    n_right = w_right[k];
                    if (w_act[k] == tea_pkg::ACT_ENCRYPT) begin
                        n_left = w_left[k]
                            + tea_pkg::mix(w_right[k], SUM_ENC, r_key0, r_key1);
                    end else begin
                        n_right = w_right[k]
                            - tea_pkg::mix(w_left[k], SUM_DEC, r_key2, r_key3);
                    end
                end
            end else begin : g_odd
                always_comb begin
                    n_left  = w_left[k];
                    n_right = w_right[k];
                    if (w_act[k] == tea_pkg::ACT_ENCRYPT) begin
                        n_right = w_right[k]
                            + tea_pkg::mix(w_left[k], SUM_ENC, r_key2, r_key3);
                    end else begin
                        n_left = w_left[k]
                            - tea_pkg::mix(w_right[k], SUM_DEC, r_key0, r_key1);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_adv) begin
                    r_valid[k] <= w_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_act[k]   <= w_act[k];
                    r_left[k]  <= n_left;
                    r_right[k] <= n_right;
                end
            end
        end
    endgenerate

    assign o_out.valid        = r_valid[LAST];
    assign o_out.result_left  = r_left[LAST];
    assign o_out.result_right = r_right[LAST];

endmodule
